### hdl/assert_macros.svh
// Assertion macros shared by the rotation-to-quaternion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("rmq assertion failed");
`define RMQ_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("rmq assertion failed");
`else
`define RMQ_ASSERT(lbl, clk, rstn, prop)
`define RMQ_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### hdl/rmq_pkg.sv
// Shared constants and stage types for the rotation-to-quaternion pipeline.
package rmq_pkg;
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int MAG_W      = DATA_WIDTH + 1;
	// The root argument is positive and below 2^(DATA_WIDTH+1), scaled by 2^FRAC_BITS.
	localparam int ROOT_W     = (DATA_WIDTH + FRAC_BITS + 2) / 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_S_W    = ROOT_W + 2;
	localparam int NUM_W      = MAG_W + FRAC_BITS + 1;
	localparam int DEN_W      = ROOT_W + 1;
	localparam int SQ_CELLS   = RAD_W / 2;
	localparam int DIV_CELLS  = NUM_W;
	localparam int LANES      = 3;

	typedef enum logic [1:0] {SEL_W, SEL_X, SEL_Y, SEL_Z} sel_t;

	typedef struct packed {
		logic                          bad;
		sel_t                          sel;
		logic [LANES-1:0]              neg;
		logic [LANES-1:0][MAG_W-1:0]   mag;
	} side_t;

	typedef struct packed {
		logic [RAD_W-1:0]   rad;
		logic [REM_S_W-1:0] rem;
		logic [ROOT_W-1:0]  root;
		side_t              side;
	} sqrt_st_t;

	typedef struct packed {
		logic [ROOT_W-1:0]             root;
		logic [LANES-1:0][NUM_W-1:0]   num;
		logic [LANES-1:0][DEN_W-1:0]   rem;
		logic [LANES-1:0][NUM_W-1:0]   quo;
		side_t                         side;
	} div_st_t;
endpackage

### hdl/rmq_if.sv
// Request channel interfaces for basis input and quaternion output.
interface rmq_basis_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] right_x, right_y, right_z;
	logic signed [DATA_WIDTH-1:0] up_x, up_y, up_z;
	logic signed [DATA_WIDTH-1:0] fwd_x, fwd_y, fwd_z;
	modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
		fwd_x, fwd_y, fwd_z, input ready);
	modport sink (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
		fwd_x, fwd_y, fwd_z, output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
	logic bad_input;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, bad_input,
		input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, bad_input,
		output ready);
endinterface

### hdl/rmq_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit from two radicand bits.
module rmq_sqrt_cell import rmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     vld_i,
	input  sqrt_st_t d_i,
	output logic     vld_o,
	output sqrt_st_t d_o
);
	logic [REM_S_W+1:0] acc;
	logic [REM_S_W+1:0] trial;
	sqrt_st_t           nxt;

	// Restoring square root step.
	always_comb begin
		nxt   = d_i;
		acc   = {d_i.rem, d_i.rad[RAD_W-1 -: 2]};
		trial = {2'b00, d_i.root, 2'b01};
		nxt.rad = {d_i.rad[RAD_W-3:0], 2'b00};
		if (acc >= trial) begin
			nxt.rem  = REM_S_W'(acc - trial);
			nxt.root = {d_i.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_S_W'(acc);
			nxt.root = {d_i.root[ROOT_W-2:0], 1'b0};
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end
endmodule

### hdl/rmq_div_cell.sv
// One cell of the divider chain: one quotient bit for each of three lanes.
module rmq_div_cell import rmq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_i,
	input  div_st_t d_i,
	output logic    vld_o,
	output div_st_t d_o
);
	logic [DEN_W-1:0] den;
	logic [DEN_W:0]   acc;
	div_st_t          nxt;

	// Restoring division step per lane against twice the root.
	always_comb begin
		nxt = d_i;
		den = {d_i.root, 1'b0};
		acc = '0;
		for (int k = 0; k < LANES; k++) begin
			acc        = {d_i.rem[k], d_i.num[k][NUM_W-1]};
			nxt.num[k] = {d_i.num[k][NUM_W-2:0], 1'b0};
			if (acc >= {1'b0, den}) begin
				nxt.rem[k] = DEN_W'(acc - {1'b0, den});
				nxt.quo[k] = {d_i.quo[k][NUM_W-2:0], 1'b1};
			end else begin
				nxt.rem[k] = DEN_W'(acc);
				nxt.quo[k] = {d_i.quo[k][NUM_W-2:0], 1'b0};
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end
endmodule

### hdl/rotation_matrix_to_quaternion.sv
// Top level: rotation basis to unit quaternion by Shepperd's method.
// Stages from request to result: 1 front stage, 16 root cells,
// 32 divider cells, 1 output register.
// Throughput: one basis per cycle; every stage advances whenever the output
// register is empty or being taken, so ready combines with the output ready.
// Reset clears all valid flags; payload registers are not reset.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rmq_basis_if.sink   basis,
	rmq_quat_if.source  quat
);
	logic en;

	// Front stage: branch choice, root argument and numerators.
	logic signed [DATA_WIDTH+1:0] trace, arg;
	logic signed [DATA_WIDTH+1:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
	logic signed [DATA_WIDTH+1:0] n_a, n_b, n_c, n_d, n_e, n_f;
	logic signed [DATA_WIDTH+1:0] nl [LANES];
	logic signed [DATA_WIDTH+1:0] one_fx;
	sqrt_st_t f_st;

	assign one_fx = (DATA_WIDTH+2)'(1 << FRAC_BITS);
	assign rx = (DATA_WIDTH+2)'(basis.right_x);
	assign ry = (DATA_WIDTH+2)'(basis.right_y);
	assign rz = (DATA_WIDTH+2)'(basis.right_z);
	assign ux = (DATA_WIDTH+2)'(basis.up_x);
	assign uy = (DATA_WIDTH+2)'(basis.up_y);
	assign uz = (DATA_WIDTH+2)'(basis.up_z);
	assign fx = (DATA_WIDTH+2)'(basis.fwd_x);
	assign fy = (DATA_WIDTH+2)'(basis.fwd_y);
	assign fz = (DATA_WIDTH+2)'(basis.fwd_z);
	assign trace = rx + uy + fz;
	assign n_a = uz - fy;
	assign n_b = fx - rz;
	assign n_c = ry - ux;
	assign n_d = ux + ry;
	assign n_e = fx + rz;
	assign n_f = fy + uz;

	always_comb begin
		f_st = '0;
		priority if (trace > 0) begin
			arg = trace + one_fx;
			f_st.side.sel = SEL_W;
			nl[0] = n_a; nl[1] = n_b; nl[2] = n_c;
		end else if (rx > uy && rx > fz) begin
			arg = one_fx + rx - uy - fz;
			f_st.side.sel = SEL_X;
			nl[0] = n_a; nl[1] = n_d; nl[2] = n_e;
		end else if (uy > fz) begin
			arg = one_fx + uy - rx - fz;
			f_st.side.sel = SEL_Y;
			nl[0] = n_b; nl[1] = n_d; nl[2] = n_f;
		end else begin
			arg = one_fx + fz - rx - uy;
			f_st.side.sel = SEL_Z;
			nl[0] = n_c; nl[1] = n_e; nl[2] = n_f;
		end
		f_st.side.bad = (arg <= 0);
		if (!f_st.side.bad) begin
			f_st.rad = RAD_W'({arg, {FRAC_BITS{1'b0}}});
		end
		for (int k = 0; k < LANES; k++) begin
			f_st.side.neg[k] = nl[k][DATA_WIDTH+1];
			f_st.side.mag[k] = nl[k][DATA_WIDTH+1] ? MAG_W'(-nl[k]) : MAG_W'(nl[k]);
		end
	end

	logic     vld_s1;
	sqrt_st_t st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= basis.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= f_st;
		end
	end

	// Square root chain.
	logic     sq_vld [SQ_CELLS+1];
	sqrt_st_t sq_st  [SQ_CELLS+1];
	assign sq_vld[0] = vld_s1;
	assign sq_st[0]  = st_s1;

	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
		rmq_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(sq_vld[i]), .d_i(sq_st[i]),
			.vld_o(sq_vld[i+1]), .d_o(sq_st[i+1])
		);
	end

	// Divider chain: numerator is magnitude scaled plus root for rounding.
	logic    dv_vld [DIV_CELLS+1];
	div_st_t dv_st  [DIV_CELLS+1];
	always_comb begin
		dv_st[0]      = '0;
		dv_st[0].root = sq_st[SQ_CELLS].root;
		dv_st[0].side = sq_st[SQ_CELLS].side;
		for (int k = 0; k < LANES; k++) begin
			dv_st[0].num[k] = {(NUM_W-MAG_W-FRAC_BITS)'(0), sq_st[SQ_CELLS].side.mag[k],
				{FRAC_BITS{1'b0}}} + NUM_W'(sq_st[SQ_CELLS].root);
		end
	end
	assign dv_vld[0] = sq_vld[SQ_CELLS];

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_dv
		rmq_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(dv_vld[i]), .d_i(dv_st[i]),
			.vld_o(dv_vld[i+1]), .d_o(dv_st[i+1])
		);
	end

	// Saturation and placement of the large component.
	div_st_t fin;
	logic [DATA_WIDTH-1:0] lane [LANES];
	logic [DATA_WIDTH-1:0] half;
	logic [DATA_WIDTH-1:0] ow, ox, oy, oz;
	localparam logic [NUM_W-1:0] QMAX = NUM_W'((1 << (DATA_WIDTH-1)) - 1);

	assign fin  = dv_st[DIV_CELLS];
	assign half = DATA_WIDTH'(((ROOT_W+1)'(fin.root) + (ROOT_W+1)'(1)) >> 1);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (fin.side.neg[k]) begin
				lane[k] = (fin.quo[k] > QMAX + 1) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
					: DATA_WIDTH'(-fin.quo[k]);
			end else begin
				lane[k] = (fin.quo[k] > QMAX) ? DATA_WIDTH'(QMAX) : DATA_WIDTH'(fin.quo[k]);
			end
		end
		unique case (fin.side.sel)
			SEL_W: begin ow = half;    ox = lane[0]; oy = lane[1]; oz = lane[2]; end
			SEL_X: begin ow = lane[0]; ox = half;    oy = lane[1]; oz = lane[2]; end
			SEL_Y: begin ow = lane[0]; ox = lane[1]; oy = half;    oz = lane[2]; end
			default: begin ow = lane[0]; ox = lane[1]; oy = lane[2]; oz = half; end
		endcase
		if (fin.side.bad) begin
			ow = '0; ox = '0; oy = '0; oz = '0;
		end
	end

	// Output register.
	logic out_vld_q;
	assign en          = !out_vld_q || quat.ready;
	assign basis.ready = en;
	assign quat.valid  = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat.quat_w    <= ow;
			quat.quat_x    <= ox;
			quat.quat_y    <= oy;
			quat.quat_z    <= oz;
			quat.bad_input <= fin.side.bad;
		end
	end

	`RMQ_ASSERT(a_bad_zero, clk, arst_n, quat.valid && quat.bad_input |-> quat.quat_w == 0 && quat.quat_x == 0 && quat.quat_y == 0 && quat.quat_z == 0)
	`RMQ_ASSERT(a_stall_blocks, clk, arst_n, quat.valid && !quat.ready |-> !basis.ready)
	`RMQ_ASSERT(a_front_valid, clk, arst_n, basis.ready |=> vld_s1 == $past(basis.valid))
endmodule

### tb/sv/tb_channels.sv
// Shared testbench types for basis requests and quaternion results.
package tb_rmq_types;
	import rmq_pkg::*;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
	} basis_t;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] w, x, y, z;
		logic                         bad;
	} quat_t;
endpackage

### tb/sv/rmq_checker.sv
// Checker that predicts each quaternion from the accepted basis and compares results.
module rmq_checker import rmq_pkg::*; import tb_rmq_types::*; (
	input  logic       clk,
	input  logic       arst_n,
	rmq_basis_if       basis,
	rmq_quat_if        quat,
	output int         fail_count,
	output int         pending
);
	quat_t quat_fifo[$];

	localparam longint SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	function automatic longint clamp(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// Integer square root by bit pairs.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Signed numerator over twice the root, magnitude rounded half away from zero.
	function automatic longint over_two_root(longint n, longint unsigned r);
		longint unsigned mag, q;
		mag = (n < 0) ? longint'(-n) : longint'(n);
		q = ((mag << FRAC_BITS) + r) / (r * 2);
		return clamp((n < 0) ? -longint'(q) : longint'(q));
	endfunction

	function automatic quat_t basis_to_quat(basis_t b);
		longint rx, ry, rz, ux, uy, uz, fx, fy, fz, tr, arg, hw, one;
		longint unsigned r;
		sel_t s;
		quat_t q;
		rx = b.rx; ry = b.ry; rz = b.rz;
		ux = b.ux; uy = b.uy; uz = b.uz;
		fx = b.fx; fy = b.fy; fz = b.fz;
		one = 64'sd1 <<< FRAC_BITS;
		tr = rx + uy + fz;
		q = '{w: 0, x: 0, y: 0, z: 0, bad: 1'b1};
		if (tr > 0) begin
			arg = tr + one; s = SEL_W;
		end else if (rx > uy && rx > fz) begin
			arg = one + rx - uy - fz; s = SEL_X;
		end else if (uy > fz) begin
			arg = one + uy - rx - fz; s = SEL_Y;
		end else begin
			arg = one + fz - rx - uy; s = SEL_Z;
		end
		if (arg <= 0) return q;
		r = int_sqrt(longint'(arg) << FRAC_BITS);
		if (r == 0) return q;
		hw = clamp(longint'((r + 1) >> 1));
		q.bad = 1'b0;
		case (s)
			SEL_W: begin
				q.w = hw; q.x = over_two_root(uz - fy, r);
				q.y = over_two_root(fx - rz, r); q.z = over_two_root(ry - ux, r);
			end
			SEL_X: begin
				q.w = over_two_root(uz - fy, r); q.x = hw;
				q.y = over_two_root(ux + ry, r); q.z = over_two_root(fx + rz, r);
			end
			SEL_Y: begin
				q.w = over_two_root(fx - rz, r); q.x = over_two_root(ux + ry, r);
				q.y = hw; q.z = over_two_root(fy + uz, r);
			end
			default: begin
				q.w = over_two_root(ry - ux, r); q.x = over_two_root(fx + rz, r);
				q.y = over_two_root(fy + uz, r); q.z = hw;
			end
		endcase
		return q;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = quat_fifo.size();

	// Predict on every accepted basis request and compare every accepted result.
	always @(posedge clk) begin
		basis_t b;
		quat_t e;
		if (arst_n) begin
			if (basis.valid && basis.ready) begin
				b = '{basis.right_x, basis.right_y, basis.right_z, basis.up_x,
					basis.up_y, basis.up_z, basis.fwd_x, basis.fwd_y, basis.fwd_z};
				quat_fifo.push_back(basis_to_quat(b));
			end
			if (quat.valid && quat.ready) begin
				if (quat_fifo.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					e = quat_fifo.pop_front();
					if (quat.quat_w !== e.w) report_mismatch("quat_w", quat.quat_w, e.w);
					if (quat.quat_x !== e.x) report_mismatch("quat_x", quat.quat_x, e.x);
					if (quat.quat_y !== e.y) report_mismatch("quat_y", quat.quat_y, e.y);
					if (quat.quat_z !== e.z) report_mismatch("quat_z", quat.quat_z, e.z);
					if (quat.bad_input !== e.bad)
						report_mismatch("bad_input", quat.bad_input, e.bad);
				end
			end
		end
	end
endmodule

### tb/sv/tb_rotation_matrix_to_quaternion.sv
// Top-level testbench: drives basis requests and random output stalls, gives the verdict.
module tb_rotation_matrix_to_quaternion import rmq_pkg::*; import tb_rmq_types::*; ();
	localparam int N_RANDOM    = 1530;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LATENCY     = 50;
	localparam logic signed [DATA_WIDTH-1:0] ONE = 1 <<< FRAC_BITS;
	localparam logic signed [DATA_WIDTH-1:0] MAXV = (1 <<< (DATA_WIDTH - 1)) - 1;
	localparam logic signed [DATA_WIDTH-1:0] MINV = -(1 <<< (DATA_WIDTH - 1));

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	bit   long_hold;

	rmq_basis_if basis();
	rmq_quat_if  quat();

	rotation_matrix_to_quaternion dut (.clk(clk), .arst_n(arst_n), .basis(basis), .quat(quat));
	rmq_checker chk (.clk(clk), .arst_n(arst_n), .basis(basis), .quat(quat),
		.fail_count(fail_count), .pending(pending));

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Cycle counter guarding against a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic signed [DATA_WIDTH-1:0] rnd_elem();
		case ($urandom_range(0, 5))
			0: return MAXV;
			1: return MINV;
			2, 3: return $signed(DATA_WIDTH'($urandom_range(0, 2 * ONE))) - ONE;
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// A proper rotation: a signed axis permutation, then rotated about one axis by a random angle.
	function automatic basis_t rnd_rotation();
		real m[3][3], a, c, s, t0, t1;
		int  p, k, i, j, sg;
		int  perms[6][3] = '{'{0,1,2}, '{1,2,0}, '{2,0,1}, '{0,2,1}, '{2,1,0}, '{1,0,2}};
		basis_t b;
		logic signed [DATA_WIDTH-1:0] v[9];
		p = $urandom_range(0, 5);
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++) m[i][j] = (perms[p][j] == i) ? 1.0 : 0.0;
		sg = (p >= 3) ? -1 : 1;
		k = $urandom_range(0, 2);
		for (i = 0; i < 3; i++) m[i][k] = m[i][k] * sg;
		a = ($urandom_range(0, 62831) / 10000.0);
		c = $cos(a); s = $sin(a);
		k = $urandom_range(0, 2);
		for (j = 0; j < 3; j++) begin
			t0 = m[(k + 1) % 3][j]; t1 = m[(k + 2) % 3][j];
			m[(k + 1) % 3][j] = c * t0 - s * t1;
			m[(k + 2) % 3][j] = s * t0 + c * t1;
		end
		for (i = 0; i < 9; i++)
			v[i] = DATA_WIDTH'($rtoi(m[i % 3][i / 3] * ONE) + $signed($urandom_range(0, 4)) - 2);
		b = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
		return b;
	endfunction

	// Valid drops only when idle cycles come between two requests.
	task automatic send_basis(basis_t b);
		int idle;
		idle = $urandom_range(0, 5);
		if (idle > 0) begin
			basis.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		basis.valid   <= 1'b1;
		basis.right_x <= b.rx; basis.right_y <= b.ry; basis.right_z <= b.rz;
		basis.up_x    <= b.ux; basis.up_y    <= b.uy; basis.up_z    <= b.uz;
		basis.fwd_x   <= b.fx; basis.fwd_y   <= b.fy; basis.fwd_z   <= b.fz;
		@(posedge clk);
		while (!basis.ready) @(posedge clk);
	endtask

	// Receiver: random stalls per result, one long hold-off while the sender keeps going.
	initial begin
		quat.ready = 1'b0;
		long_hold = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				quat.ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end
			if ($urandom_range(0, 3) == 0) begin
				quat.ready <= 1'b1;
				@(posedge clk);
			end else begin
				quat.ready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(posedge clk);
				quat.ready <= 1'b1;
				@(posedge clk);
				while (!quat.valid) @(posedge clk);
			end
		end
	end

	// Stimulus: directed corners, then mostly proper rotations with some raw noise.
	initial begin
		basis_t b;
		int i, w;
		cycles = 0;
		arst_n = 1'b0;
		basis.valid = 1'b0;
		{basis.right_x, basis.right_y, basis.right_z} = '0;
		{basis.up_x, basis.up_y, basis.up_z} = '0;
		{basis.fwd_x, basis.fwd_y, basis.fwd_z} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity, half turns about each axis, diagonal ties and a zero matrix.
		send_basis('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
		send_basis('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
		send_basis('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE});
		send_basis('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE});
		send_basis('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
		send_basis('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send_basis('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -2 * ONE});
		send_basis('{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE});
		// Most negative diagonal entries, which take the z diagonal branch.
		send_basis('{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV});
		send_basis('{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, -2});
		// Largest trace and saturating off-diagonal terms.
		send_basis('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
		send_basis('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
		send_basis('{1, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 0});
		send_basis('{-ONE, MAXV, MAXV, MAXV, -ONE, MAXV, MAXV, MAXV, -ONE + 1});
		send_basis('{MAXV, MINV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MINV});
		send_basis('{0, MINV, MAXV, MAXV, 0, MINV, MINV, MAXV, 1});

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) long_hold = 1'b1;
			w = $urandom_range(0, 9);
			if (w < 7) begin
				b = rnd_rotation();
			end else begin
				b = '{rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
					rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
			end
			// Occasional back-to-back bursts without idle cycles.
			if (w == 9) begin
				basis.valid <= 1'b1;
				basis.right_x <= b.rx; basis.right_y <= b.ry; basis.right_z <= b.rz;
				basis.up_x <= b.ux; basis.up_y <= b.uy; basis.up_z <= b.uz;
				basis.fwd_x <= b.fx; basis.fwd_y <= b.fy; basis.fwd_z <= b.fz;
				@(posedge clk);
				while (!basis.ready) @(posedge clk);
			end else begin
				send_basis(b);
			end
		end
		basis.valid <= 1'b0;

		// Drain, then let the pipeline settle.
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
